/* rtl/core/lossy_range_set_union_assert.svh */
// assertion macros for the lossy range set union checker
`ifndef LOSSY_RANGE_SET_UNION_ASSERT_SVH
`define LOSSY_RANGE_SET_UNION_ASSERT_SVH

// same-cycle implication, off while in reset
`define LRSU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrsu assertion failed");

// next-cycle implication, off while in reset
`define LRSU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrsu assertion failed");

// condition that must hold in the cycle after reset
`define LRSU_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("lrsu assertion failed");

`endif

/* rtl/core/lrsu_pkg.sv */
// types and constants shared by the lossy range set union modules
package lrsu_pkg;

  localparam int BOUND_BITS = 31;
  // most results one item can cause
  localparam int RES_MAX = 3;

  typedef logic [BOUND_BITS-1:0] bound_t;
  typedef logic [1:0] mode_t;
  typedef logic [1:0] res_cnt_t;

  localparam mode_t MODE_KEEP     = 2'd0;
  localparam mode_t MODE_LOSSLESS = 2'd1;
  localparam mode_t MODE_LOSSY    = 2'd2;

  typedef struct packed {
    bound_t range_lower;
    bound_t range_upper;
    logic   range_lossy;
    logic   input_last;
  } in_t;

  typedef struct packed {
    bound_t out_lower;
    bound_t out_upper;
    logic   out_lossy;
    logic   run_end;
    logic   set_end;
  } out_t;

  typedef struct packed {
    bound_t lo;
    bound_t up;
    logic   lossy;
  } span_t;

  typedef struct packed {
    logic  vld;
    span_t spn;
  } pend_t;

  // what the merge logic hands back for one item
  typedef struct packed {
    out_t [RES_MAX-1:0] res;
    res_cnt_t           cnt;
    pend_t              pend;
  } step_t;

endpackage

/* rtl/core/lossy_range_set_union.sv */
// top level of the lossy range set union
//
// streaming union of sorted closed ranges that carry a lossy flag
// item channel: item_valid / item_ready / item_data, one range per transfer,
//   sorted by lower bound; input_last ends a set and flushes the pending range
// result channel: result_valid / result_ready / result_data, one finished
//   range per transfer; run_end marks the last result an item caused and
//   set_end the final range of a set
// cfg_wr_en / cfg_wr_data write lossiness_mode; the user must write it only while idle, not enforced
// an item's results pass through the input register, then the result queue
// throughput: one item per cycle while items cause at most one result each and
//   the receiver keeps taking results; an item with two or three results is
//   bound by the one-result-per-cycle read port of the result queue
// the item side keeps taking items while results wait in the queue; it only
//   stops when the queue lacks room for the next item's results
// reset clears the pending range, the queue and the mode (keep lossiness)
// a stalled receiver holds result_data steady until the transfer
module lossy_range_set_union import lrsu_pkg::*; #(
  // result queue depth, a power of two from 4 to 32
  parameter int OUT_DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  in_t   item_data,
  output logic  result_valid,
  input  logic  result_ready,
  output out_t  result_data,
  input  logic  cfg_wr_en,
  input  mode_t cfg_wr_data
);

  localparam int CW = $clog2(OUT_DEPTH + 1);

  // input register
  logic  in_vld;
  in_t   in_reg;

  // pending range and mode register
  pend_t pend;
  mode_t mode;

  step_t         step;
  logic          fire;
  logic          pop;
  logic [CW-1:0] q_count;
  logic [CW-1:0] q_free;

  // combine the registered item with the pending range
  lrsu_merge u_merge (
    .item (in_reg),
    .pend (pend),
    .mode (mode),
    .step (step)
  );

  // item leaves the input register once all its results fit in the queue
  assign q_free     = CW'(OUT_DEPTH) - q_count;
  assign fire       = in_vld && (CW'(step.cnt) <= q_free);
  assign item_ready = !in_vld || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (item_ready) begin
      in_vld <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      in_reg <= item_data;
    end
  end

  // pending range moves on with each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (fire) begin
      pend <= step.pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_KEEP;
    end else if (cfg_wr_en) begin
      mode <= cfg_wr_data;
    end
  end

  // result queue decouples the receiver from the merge logic
  lrsu_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (fire ? step.cnt : res_cnt_t'(0)),
    .push_data (step.res),
    .pop       (pop),
    .head      (result_data),
    .count     (q_count)
  );

  assign result_valid = (q_count != '0);
  assign pop          = result_valid && result_ready;

endmodule

/* rtl/core/lrsu_merge.sv */
// merge logic: combines one item with the pending range, lists finished ranges
module lrsu_merge import lrsu_pkg::*; (
  input  in_t   item,
  input  pend_t pend,
  input  mode_t mode,
  output step_t step
);

  function automatic bound_t succ_sat(bound_t v);
    return (&v) ? v : v + bound_t'(1);
  endfunction

  function automatic bound_t pred_sat(bound_t v);
    return (v == '0) ? v : v - bound_t'(1);
  endfunction

  function automatic bound_t max_b(bound_t x, bound_t y);
    return (x > y) ? x : y;
  endfunction

  function automatic bound_t min_b(bound_t x, bound_t y);
    return (x < y) ? x : y;
  endfunction

  function automatic span_t mk_span(bound_t lo, bound_t up, logic lossy);
    span_t s;
    s.lo    = lo;
    s.up    = up;
    s.lossy = lossy;
    return s;
  endfunction

  function automatic out_t mk_out(span_t s);
    out_t o;
    o           = '0;
    o.out_lower = s.lo;
    o.out_upper = s.up;
    o.out_lossy = s.lossy;
    return o;
  endfunction

  always_comb begin
    span_t              nx;
    span_t              a;
    span_t              b;
    span_t              cov;
    span_t              inner;
    span_t              cur;
    logic               ovl;
    logic               adj;
    bound_t             left_up;
    bound_t             right_lo;
    logic [BOUND_BITS:0] a_up1;
    logic [BOUND_BITS:0] b_up1;
    out_t [RES_MAX-1:0] res;
    res_cnt_t           cnt;

    // normalize the incoming range
    nx.lo = item.range_lower;
    nx.up = (item.range_upper < item.range_lower) ? item.range_lower : item.range_upper;
    case (mode)
      MODE_LOSSLESS: nx.lossy = 1'b0;
      MODE_LOSSY:    nx.lossy = 1'b1;
      default:       nx.lossy = item.range_lossy;
    endcase

    // order the two ranges by lower bound
    if (pend.spn.lo > nx.lo) begin
      a = nx;
      b = pend.spn;
    end else begin
      a = pend.spn;
      b = nx;
    end
    ovl   = (a.lo <= b.up) && (b.lo <= a.up);
    a_up1 = {1'b0, a.up} + {{BOUND_BITS{1'b0}}, 1'b1};
    b_up1 = {1'b0, b.up} + {{BOUND_BITS{1'b0}}, 1'b1};
    adj   = (a_up1 == {1'b0, b.lo}) || (b_up1 == {1'b0, a.lo});

    // covering range and the one inside it
    if (b.up <= a.up) begin
      cov   = a;
      inner = b;
    end else begin
      cov   = b;
      inner = a;
    end
    left_up  = max_b(pred_sat(inner.lo), cov.lo);
    right_lo = min_b(succ_sat(inner.up), cov.up);

    res = '0;
    cnt = '0;
    cur = nx;

    if (pend.vld) begin
      if (ovl) begin
        if (a.lossy == b.lossy) begin
          cur = mk_span(a.lo, max_b(a.up, b.up), a.lossy);
        end else if ((b.up <= a.up) || (b.lo == a.lo)) begin
          if (!cov.lossy) begin
            cur = cov;
          end else begin
            // lossy cover split around the lossless inner range
            if (inner.lo > left_up) begin
              res[cnt] = mk_out(mk_span(cov.lo, left_up, 1'b1));
              cnt      = cnt + res_cnt_t'(1);
            end
            if (right_lo > inner.up) begin
              res[cnt] = mk_out(inner);
              cnt      = cnt + res_cnt_t'(1);
              cur      = mk_span(right_lo, cov.up, 1'b1);
            end else begin
              cur = inner;
            end
          end
        end else if (!a.lossy) begin
          res[cnt] = mk_out(a);
          cnt      = cnt + res_cnt_t'(1);
          cur      = mk_span(succ_sat(a.up), b.up, b.lossy);
        end else begin
          res[cnt] = mk_out(mk_span(a.lo, pred_sat(b.lo), a.lossy));
          cnt      = cnt + res_cnt_t'(1);
          cur      = b;
        end
      end else if ((a.lossy == b.lossy) && adj) begin
        cur = mk_span(a.lo, max_b(a.up, b.up), a.lossy);
      end else begin
        res[cnt] = mk_out(a);
        cnt      = cnt + res_cnt_t'(1);
        cur      = b;
      end
    end

    // last item flushes the pending range
    if (item.input_last) begin
      res[cnt]         = mk_out(cur);
      res[cnt].set_end = 1'b1;
      cnt              = cnt + res_cnt_t'(1);
      step.pend        = '0;
    end else begin
      step.pend.vld = 1'b1;
      step.pend.spn = cur;
    end

    if (cnt != '0) begin
      res[cnt - res_cnt_t'(1)].run_end = 1'b1;
    end

    step.res = res;
    step.cnt = cnt;
  end

endmodule

/* rtl/core/lrsu_out_fifo.sv */
// result queue: takes up to three results a cycle, hands out one
module lrsu_out_fifo import lrsu_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  res_cnt_t                   push_cnt,
  input  out_t [RES_MAX-1:0]         push_data,
  input  logic                       pop,
  output out_t                       head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  out_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (res_cnt_t'(i) < push_cnt) begin
        mem[wr_ptr + AW'(i)] <= push_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push_cnt);
      rd_ptr <= rd_ptr + AW'(pop);
      count  <= count + CW'(push_cnt) - CW'(pop);
    end
  end

  assign head = mem[rd_ptr];

endmodule

/* rtl/core/lrsu_checker.sv */
// port-level checker for the lossy range set union, bound to the top level
`include "lossy_range_set_union_assert.svh"

module lrsu_checker import lrsu_pkg::*; (
  input logic clk,
  input logic rst,
  input logic result_valid,
  input logic result_ready,
  input out_t result_data
);

  // queue is empty right after reset
  `LRSU_ASSERT_RST(a_idle_after_reset, !result_valid)
  // a stalled result stays put
  `LRSU_ASSERT_NXT(a_hold_on_stall, result_valid && !result_ready, result_valid && $stable(result_data))
  // the end of a set is always the end of the item's run
  `LRSU_ASSERT_IMP(a_set_end_ends_run, result_valid && result_data.set_end, result_data.run_end)
  // every emitted range has ordered bounds
  `LRSU_ASSERT_IMP(a_bounds_ordered, result_valid, result_data.out_lower <= result_data.out_upper)

endmodule

bind lossy_range_set_union lrsu_checker u_lrsu_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_data  (result_data)
);
